[hdl/vwib_pkg.sv]
// Package for the vertex weld index builder: widths, constants and record types.
package vwib_pkg;

	localparam int MaxVertices = 1024;
	localparam int AddrW = 10;
	localparam int CountW = 11;
	localparam int CompW = 32;
	localparam int UnitW = 18;
	localparam int TolW = 16;
	localparam int EntryW = 8 * CompW;

	// Configuration register indexes.
	localparam logic [0:0] RegMaxEntries = 1'd0;
	localparam logic [0:0] RegTolerance = 1'd1;

	localparam logic [CountW-1:0] MaxEntriesReset = 11'd1024;
	localparam logic [TolW-1:0] ToleranceReset = 16'd1;

	// One stored vertex, first input component in the lowest bits.
	typedef struct packed {
		logic signed [CompW-1:0] tex_v;
		logic signed [CompW-1:0] tex_u;
		logic signed [CompW-1:0] norm_z;
		logic signed [CompW-1:0] norm_y;
		logic signed [CompW-1:0] norm_x;
		logic signed [CompW-1:0] pos_z;
		logic signed [CompW-1:0] pos_y;
		logic signed [CompW-1:0] pos_x;
	} entry_t;

	// Result item.
	typedef struct packed {
		logic [CountW-1:0] vertex_count;
		logic [CountW-1:0] index_count;
		logic signed [UnitW-1:0] unit_norm_z;
		logic signed [UnitW-1:0] unit_norm_y;
		logic signed [UnitW-1:0] unit_norm_x;
		logic dropped;
		logic is_new;
		logic [AddrW-1:0] vertex_index;
	} result_t;

	// One-hot sequencer states.
	typedef enum logic [8:0] {
		ST_IDLE  = 9'b000000001,
		ST_SQ    = 9'b000000010,
		ST_SQRT  = 9'b000000100,
		ST_DIV   = 9'b000001000,
		ST_SCAN  = 9'b000010000,
		ST_CMP   = 9'b000100000,
		ST_DEC   = 9'b001000000,
		ST_OUT   = 9'b010000000,
		ST_SUM   = 9'b100000000
	} state_t;

endpackage

[hdl/vertex_weld_index_builder.sv]
// Top level of the vertex weld index builder: normalizer, store scan and counters.
//
// Usage: one vertex request enters on the s_axis group (tdata fields below) and one
// result leaves on the m_axis group. Configuration is written through cfg_we,
// cfg_addr and cfg_data: index 0 is max_entries, index 1 is tolerance. The user
// must write it only while the block is idle; the block itself does not enforce this.
// Steps per item: the normal is squared and summed, its length is found by a bit-pair
// square root, the three components are divided by restoring divisions, then the
// stored vertices are scanned (a read of the vertex memory and a compare for each),
// and at the end the block decides, writes back and presents the result.
// One item is handled at a time; s_axis_tready is high only when the block is
// idle and the output register is free.
// Reset clears the counts and sets max_entries to 1024 and tolerance to 1; the
// vertex memory is not cleared, since only entries below the count are read.
// When the receiver stalls, the result waits in the output register and the
// block takes the next request as soon as that register is emptied.
module vertex_weld_index_builder (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [0:0]   cfg_addr,
	input  logic [15:0]  cfg_data,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// tuser: new_batch
	input  logic         s_axis_tuser,
	// tdata: pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, tex_u, tex_v
	input  logic [255:0] s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// tdata: vertex_index, is_new, dropped, unit_norm_x, unit_norm_y, unit_norm_z,
	// index_count, vertex_count
	output logic [87:0]  m_axis_tdata
);

	localparam int CW = vwib_pkg::CountW;
	localparam int AW = vwib_pkg::AddrW;

	vwib_pkg::state_t state_q;
	vwib_pkg::entry_t in_q;
	vwib_pkg::result_t res_q;
	logic              out_valid_q;
	logic [CW-1:0]     max_q;
	logic [vwib_pkg::TolW-1:0] tol_q;
	logic [CW-1:0]     uniq_q, emit_q;

	// Normalization datapath.
	logic [63:0]  sq_q [3];
	logic [1:0]   sq_idx_q;
	logic [63:0]  rem_q, res_sq_q, bit_q;
	logic [31:0]  len_q;
	logic [1:0]   cmp_q;
	logic [5:0]   step_q;
	logic [48:0]  dnum_q;
	logic [49:0]  drem_q;
	logic [17:0]  quot_q;
	logic         dneg_q;
	logic signed [vwib_pkg::UnitW-1:0] unit_q [3];

	// Scan.
	logic [AW:0]  scan_q;
	logic         hit_q;
	logic [AW-1:0] hit_idx_q;
	vwib_pkg::entry_t rd_data, key;
	logic         we;

	logic in_acc;
	assign s_axis_tready = (state_q == vwib_pkg::ST_IDLE) && !out_valid_q;
	assign in_acc = s_axis_tvalid && s_axis_tready;

	// Compare key built from the inputs and the unit normal.
	always_comb begin
		key = in_q;
		key.norm_x = 32'(unit_q[0]);
		key.norm_y = 32'(unit_q[1]);
		key.norm_z = 32'(unit_q[2]);
	end

	logic [CW-1:0] cap;
	assign cap = (max_q < CW'(vwib_pkg::MaxVertices)) ? max_q : CW'(vwib_pkg::MaxVertices);

	logic do_hit, do_new;
	assign do_hit = hit_q && (emit_q < cap);
	assign do_new = !hit_q && (uniq_q < cap) && (emit_q < cap);
	assign we = (state_q == vwib_pkg::ST_DEC) && do_new;

	vwib_ram #(.Width(vwib_pkg::EntryW), .Depth(vwib_pkg::MaxVertices)) u_store (
		.clk   (clk),
		.we    (we),
		.waddr (uniq_q[AW-1:0]),
		.wdata (key),
		.raddr (scan_q[AW-1:0]),
		.rdata (rd_data)
	);

	// Squaring unit input, one component per cycle.
	logic signed [31:0] sq_in;
	logic [31:0] sq_mag;
	always_comb begin
		case (sq_idx_q)
			2'd0:    sq_in = in_q.norm_x;
			2'd1:    sq_in = in_q.norm_y;
			default: sq_in = in_q.norm_z;
		endcase
		sq_mag = sq_in[31] ? 32'(-sq_in) : 32'(sq_in);
	end

	// Divider input select.
	logic signed [31:0] div_in;
	always_comb begin
		case (cmp_q)
			2'd0:    div_in = in_q.norm_x;
			2'd1:    div_in = in_q.norm_y;
			default: div_in = in_q.norm_z;
		endcase
	end

	// Component match against the tolerance.
	function automatic logic near_f(input logic signed [31:0] a, input logic signed [31:0] b,
		input logic [15:0] t);
		logic signed [32:0] d;
		logic [32:0] m;
		d = 33'(a) - 33'(b);
		m = d[32] ? 33'(-d) : 33'(d);
		return m < 33'(t);
	endfunction

	logic all_near;
	assign all_near = near_f(rd_data.pos_x, key.pos_x, tol_q) &&
		near_f(rd_data.pos_y, key.pos_y, tol_q) && near_f(rd_data.pos_z, key.pos_z, tol_q) &&
		near_f(rd_data.norm_x, key.norm_x, tol_q) && near_f(rd_data.norm_y, key.norm_y, tol_q) &&
		near_f(rd_data.norm_z, key.norm_z, tol_q) && near_f(rd_data.tex_u, key.tex_u, tol_q) &&
		near_f(rd_data.tex_v, key.tex_v, tol_q);

	logic [63:0] trial;
	assign trial = res_sq_q + bit_q;
	logic [49:0] dshift;
	assign dshift = {drem_q[48:0], dnum_q[48]};

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= vwib_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
			max_q       <= vwib_pkg::MaxEntriesReset;
			tol_q       <= vwib_pkg::ToleranceReset;
			uniq_q      <= '0;
			emit_q      <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_addr)
					vwib_pkg::RegMaxEntries: max_q <= cfg_data[CW-1:0];
					vwib_pkg::RegTolerance:  tol_q <= cfg_data;
					default: ;
				endcase
			end
			if (out_valid_q && m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				vwib_pkg::ST_IDLE: begin
					if (in_acc) begin
						in_q     <= s_axis_tdata;
						sq_idx_q <= 2'd0;
						if (s_axis_tuser) begin
							uniq_q <= '0;
							emit_q <= '0;
						end
						state_q <= vwib_pkg::ST_SQ;
					end
				end
				vwib_pkg::ST_SQ: begin
					sq_q[sq_idx_q] <= 64'(sq_mag) * 64'(sq_mag);
					sq_idx_q <= sq_idx_q + 2'd1;
					if (sq_idx_q == 2'd2) begin
						state_q <= vwib_pkg::ST_SUM;
					end
				end
				vwib_pkg::ST_SUM: begin
					rem_q    <= sq_q[0] + sq_q[1] + sq_q[2];
					res_sq_q <= '0;
					bit_q    <= 64'h4000_0000_0000_0000;
					state_q  <= vwib_pkg::ST_SQRT;
				end
				vwib_pkg::ST_SQRT: begin
					if (rem_q >= trial) begin
						rem_q    <= rem_q - trial;
						res_sq_q <= (res_sq_q >> 1) + bit_q;
					end else begin
						res_sq_q <= res_sq_q >> 1;
					end
					bit_q <= bit_q >> 2;
					if (bit_q == 64'd1) begin
						len_q <= (rem_q >= trial) ? 32'((res_sq_q >> 1) + bit_q)
							: 32'(res_sq_q >> 1);
						cmp_q  <= 2'd0;
						step_q <= '0;
						state_q <= vwib_pkg::ST_DIV;
					end
				end
				vwib_pkg::ST_DIV: begin
					if (step_q == 6'd0) begin
						// Load numerator |n| * 65536 + len / 2.
						dneg_q <= div_in[31];
						dnum_q <= ({17'd0, (div_in[31] ? 32'(-div_in) : 32'(div_in))} << 16)
							+ 49'(len_q >> 1);
						drem_q <= '0;
						quot_q <= '0;
						step_q <= 6'd1;
					end else if (step_q <= 6'd49) begin
						dnum_q <= dnum_q << 1;
						if (dshift >= 50'(len_q)) begin
							drem_q <= dshift - 50'(len_q);
							quot_q <= {quot_q[16:0], 1'b1};
						end else begin
							drem_q <= dshift;
							quot_q <= {quot_q[16:0], 1'b0};
						end
						step_q <= step_q + 6'd1;
					end else begin
						if (len_q == '0) begin
							unit_q[cmp_q] <= '0;
						end else begin
							unit_q[cmp_q] <= dneg_q ? -$signed(quot_q) : $signed(quot_q);
						end
						step_q <= '0;
						cmp_q  <= cmp_q + 2'd1;
						if (cmp_q == 2'd2) begin
							scan_q  <= '0;
							hit_q   <= 1'b0;
							state_q <= vwib_pkg::ST_SCAN;
						end
					end
				end
				vwib_pkg::ST_SCAN: begin
					if (scan_q >= (AW+1)'(uniq_q)) begin
						state_q <= vwib_pkg::ST_DEC;
					end else begin
						state_q <= vwib_pkg::ST_CMP;
					end
				end
				vwib_pkg::ST_CMP: begin
					if (all_near) begin
						hit_q     <= 1'b1;
						hit_idx_q <= scan_q[AW-1:0];
						state_q   <= vwib_pkg::ST_DEC;
					end else begin
						scan_q  <= scan_q + 1'b1;
						state_q <= vwib_pkg::ST_SCAN;
					end
				end
				vwib_pkg::ST_DEC: begin
					res_q.unit_norm_x <= unit_q[0];
					res_q.unit_norm_y <= unit_q[1];
					res_q.unit_norm_z <= unit_q[2];
					res_q.is_new      <= do_new;
					res_q.dropped     <= !do_hit && !do_new;
					res_q.vertex_index <= do_hit ? hit_idx_q : (do_new ? uniq_q[AW-1:0] : '0);
					res_q.index_count  <= (do_hit || do_new) ? emit_q + 1'b1 : emit_q;
					res_q.vertex_count <= do_new ? uniq_q + 1'b1 : uniq_q;
					if (do_hit || do_new) emit_q <= emit_q + 1'b1;
					if (do_new) uniq_q <= uniq_q + 1'b1;
					state_q <= vwib_pkg::ST_OUT;
				end
				vwib_pkg::ST_OUT: begin
					out_valid_q <= 1'b1;
					state_q     <= vwib_pkg::ST_IDLE;
				end
				default: state_q <= vwib_pkg::ST_IDLE;
			endcase
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = res_q;

endmodule

[hdl/vwib_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module vwib_ram #(
	parameter int Width = 8,
	parameter int Depth = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);

	logic [Width-1:0] mem [Depth];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
